// ===== sv/axdz_pkg.sv =====
`default_nettype none
package axdz_pkg;

  // sequencer states of the normalizer
  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_PREP,
    S_DIV,
    S_OUT
  } state_t;

  // divider operand width: magnitudes up to 32768
  localparam int OPW = 17;

  // sample and result field width
  localparam int SAMPLE_W = 16;

  // fraction bits of the sample scale: full deflection is 2^FRAC_BITS
  localparam int FRAC_BITS = 14;

  // register reset values
  localparam logic [13:0] DZ_RESET = 14'd3277;
  localparam logic [14:0] IR_RESET = 15'd14746;

  // register indexes on the configuration port
  localparam logic [0:0] REG_DZ         = 1'b0;
  localparam logic [0:0] REG_INIT_RANGE = 1'b1;

endpackage
`default_nettype wire

// ===== sv/axdz_ram.sv =====
`default_nettype none
module axdz_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   wr_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                       wr_data,
  input  wire logic                                   rd_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ===== sv/axdz_div.sv =====
`default_nettype none
module axdz_div #(
  parameter int QW = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [axdz_pkg::OPW-1:0]  dividend,
  input  wire logic [axdz_pkg::OPW-1:0]  divisor,
  output logic                           done,
  output logic      [QW-1:0]             quotient
);

  localparam int CNT_W = $clog2(QW + 1);

  logic [axdz_pkg::OPW:0]   rem_r;
  logic [axdz_pkg::OPW-1:0] den_r;
  logic [QW-1:0]            quo_r;
  logic [CNT_W-1:0]         cnt_r;
  logic                     busy_r;
  logic                     first_r;
  logic                     done_r;

  logic [axdz_pkg::OPW:0]   shifted;
  logic                     ge;
  logic [axdz_pkg::OPW:0]   rem_nxt;

  // one restoring step: the first step takes the integer bit without a shift
  always_comb begin
    shifted = first_r ? rem_r : {rem_r[axdz_pkg::OPW-1:0], 1'b0};
    ge      = shifted >= {1'b0, den_r};
    rem_nxt = ge ? shifted - {1'b0, den_r} : shifted;
  end

  // control: count quotient bits, pulse done after the last
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      first_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        first_r <= 1'b1;
        cnt_r   <= CNT_W'(QW);
      end else if (busy_r) begin
        first_r <= 1'b0;
        cnt_r   <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: remainder and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {1'b0, dividend};
      den_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[QW-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

// ===== sv/axis_deadzone_range_normalizer.sv =====
// Dead-zone removal and auto-ranging for up to N_AXES stick axes, in signed
// fixed point where 2^FRAC_BITS is full deflection. Each input word carries
// an axis index and a raw sample (tuser: clear flag that reloads the axis range
// from initial_range first). The sample is zeroed inside the dead zone, clamped
// to +/-1.0, widens the per-axis max/min kept in a registered-read RAM, and
// outside the dead zone is rescaled by a bit-serial divider to +/-1.0 with
// round-to-nearest. One word is in flight at a time: an active sample waits
// for the divider, which retires one quotient bit per cycle, before the next
// acceptance, and a sample inside the dead zone skips the divider. Axis
// ranges start at +/-14746 out of reset with no clearing pass. Indexes at
// or above N_AXES wrap modulo N_AXES. A finished result waits in the
// output register and the next word is accepted meanwhile.
`default_nettype none
module axis_deadzone_range_normalizer #(
  parameter int N_AXES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration writes
  input  wire logic        cfg_wr_en,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [14:0] cfg_wdata,
  // input words
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // axis[3:0], raw_sample[19:4], zero pad
  input  wire logic        in_tuser,   // clear_range
  // result words
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [39:0] out_tdata,  // axis_out[3:0], normalized[19:4],
                                       // clamped_raw[35:20], zero pad
  output logic             out_tuser   // active
);

  localparam int AX_W = (N_AXES > 1) ? $clog2(N_AXES) : 1;
  localparam int QW   = axdz_pkg::FRAC_BITS + 2;
  localparam int CW   = (axdz_pkg::FRAC_BITS + 2 > 17) ? axdz_pkg::FRAC_BITS + 2 : 17;
  localparam int SW   = axdz_pkg::SAMPLE_W;
  localparam int OPW  = axdz_pkg::OPW;

  axdz_pkg::state_t state_r, state_nxt;

  // configuration registers
  logic [13:0] dz_r;
  logic [14:0] ir_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dz_r <= axdz_pkg::DZ_RESET;
      ir_r <= axdz_pkg::IR_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        axdz_pkg::REG_DZ:         dz_r <= cfg_wdata[13:0];
        axdz_pkg::REG_INIT_RANGE: ir_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // axis index wrap table
  logic [AX_W-1:0] ax_map [16];
  for (genvar gi = 0; gi < 16; gi++) begin : g_map
    assign ax_map[gi] = AX_W'(gi % N_AXES);
  end

  // control strobes from the sequencer
  logic in_acc;
  logic ram_wr;
  logic div_start;
  logic out_load;
  logic out_free;

  assign out_free = !out_tvalid || out_tready;

  // dead zone and clamp on the incoming sample
  logic signed [CW-1:0] s_c;
  logic signed [CW-1:0] dz_c;
  logic signed [CW-1:0] one_c;
  logic signed [CW-1:0] z_c;
  logic signed [CW-1:0] v_c;
  logic                 act_c;

  always_comb begin
    s_c   = $signed({{(CW-SW){in_tdata[19]}}, in_tdata[19:4]});
    dz_c  = $signed({{(CW-14){1'b0}}, dz_r});
    one_c = $signed(CW'(1) << axdz_pkg::FRAC_BITS);
    z_c   = ((s_c < dz_c) && (s_c > -dz_c)) ? '0 : s_c;
    if (z_c > one_c) begin
      v_c = one_c;
    end else if (z_c < -one_c) begin
      v_c = -one_c;
    end else begin
      v_c = z_c;
    end
    act_c = (v_c > dz_c) || (v_c < -dz_c);
  end

  // per-axis valid bits: an unwritten entry reads as the reset range
  logic [N_AXES-1:0] vld_r;
  logic [AX_W-1:0]   ax_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ram_wr) begin
      vld_r[ax_r] <= 1'b1;
    end
  end

  // word registers captured at acceptance
  logic [3:0]           ax_in_r;
  logic                 clr_r;
  logic                 hit_r;
  logic                 act_r;
  logic signed [SW-1:0] v_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ax_in_r <= in_tdata[3:0];
      ax_r    <= ax_map[in_tdata[3:0]];
      clr_r   <= in_tuser;
      hit_r   <= vld_r[ax_map[in_tdata[3:0]]];
      act_r   <= act_c;
      v_r     <= v_c[SW-1:0];
    end
  end

  // range memory: {max, min} per axis
  logic [2*SW-1:0] rd_data;
  logic [2*SW-1:0] wr_data;

  axdz_ram #(
    .WIDTH (2 * SW),
    .DEPTH (N_AXES)
  ) u_range_ram (
    .clk     (clk),
    .wr_en   (ram_wr),
    .wr_addr (ax_r),
    .wr_data (wr_data),
    .rd_en   (in_acc),
    .rd_addr (ax_map[in_tdata[3:0]]),
    .rd_data (rd_data)
  );

  // reload or widen the range, then write it back
  logic signed [SW-1:0] base_max;
  logic signed [SW-1:0] base_min;
  logic signed [SW-1:0] new_max;
  logic signed [SW-1:0] new_min;
  logic signed [SW-1:0] rmax_r;
  logic signed [SW-1:0] rmin_r;

  always_comb begin
    if (clr_r) begin
      base_max = $signed({1'b0, ir_r});
      base_min = -$signed({1'b0, ir_r});
    end else if (hit_r) begin
      base_max = $signed(rd_data[2*SW-1:SW]);
      base_min = $signed(rd_data[SW-1:0]);
    end else begin
      base_max = $signed({1'b0, axdz_pkg::IR_RESET});
      base_min = -$signed({1'b0, axdz_pkg::IR_RESET});
    end
    new_max = (v_r > base_max) ? v_r : base_max;
    new_min = (v_r < base_min) ? v_r : base_min;
    wr_data = {new_max, new_min};
  end

  always_ff @(posedge clk) begin
    if (ram_wr) begin
      rmax_r <= new_max;
      rmin_r <= new_min;
    end
  end

  // distance past the dead zone and tracked range past it
  logic signed [OPW:0] v_x;
  logic signed [OPW:0] dz_x;
  logic signed [OPW:0] num_x;
  logic signed [OPW:0] den_x;
  logic                pos;

  always_comb begin
    pos  = !v_r[SW-1];
    v_x  = $signed({{(OPW+1-SW){v_r[SW-1]}}, v_r});
    dz_x = $signed({{(OPW+1-14){1'b0}}, dz_r});
    if (pos) begin
      num_x = v_x - dz_x;
      den_x = $signed({{(OPW+1-SW){rmax_r[SW-1]}}, rmax_r}) - dz_x;
    end else begin
      num_x = -v_x - dz_x;
      den_x = -$signed({{(OPW+1-SW){rmin_r[SW-1]}}, rmin_r}) - dz_x;
    end
  end

  logic          div_done;
  logic [QW-1:0] quotient;

  axdz_div #(
    .QW (QW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (num_x[OPW-1:0]),
    .divisor  (den_x[OPW-1:0]),
    .done     (div_done),
    .quotient (quotient)
  );

  // round the doubled quotient and restore the sign
  logic [QW-1:0] q_inc;
  logic [SW-1:0] mag;
  logic [SW-1:0] norm;

  always_comb begin
    q_inc = quotient + QW'(1);
    mag   = SW'(q_inc[QW-1:1]);
    if (!act_r) begin
      norm = '0;
    end else if (pos) begin
      norm = mag;
    end else begin
      norm = -mag;
    end
  end

  // sequencer: next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      axdz_pkg::S_IDLE: if (in_tvalid) state_nxt = axdz_pkg::S_READ;
      axdz_pkg::S_READ: state_nxt = axdz_pkg::S_PREP;
      axdz_pkg::S_PREP: state_nxt = act_r ? axdz_pkg::S_DIV : axdz_pkg::S_OUT;
      axdz_pkg::S_DIV:  if (div_done) state_nxt = axdz_pkg::S_OUT;
      axdz_pkg::S_OUT:  if (out_free) state_nxt = axdz_pkg::S_IDLE;
      default:          state_nxt = axdz_pkg::S_IDLE;
    endcase
  end

  // sequencer: strobes
  always_comb begin
    in_tready = 1'b0;
    ram_wr    = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      axdz_pkg::S_IDLE: in_tready = 1'b1;
      axdz_pkg::S_READ: ram_wr    = 1'b1;
      axdz_pkg::S_PREP: div_start = act_r;
      axdz_pkg::S_DIV:  ;
      axdz_pkg::S_OUT:  out_load  = out_free;
      default:          ;
    endcase
  end

  assign in_acc = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= axdz_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // output register: hold the result until taken
  logic        out_tvalid_r;
  logic [39:0] out_tdata_r;
  logic        out_tuser_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= {4'b0000, v_r, norm, ax_in_r};
      out_tuser_r <= act_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule
`default_nettype wire
